// ===== hw/rtl/wfv_pkg.sv =====
`timescale 1ns / 1ps
package wfv_pkg;
  localparam int unsigned MAX_KEY_BYTES    = 1048576;
  localparam int unsigned MAX_RECORD_BYTES = 16777216;
  localparam int unsigned HDR_BYTES        = 32;
  localparam int unsigned REC_MIN          = 29;
  localparam logic [31:0] MAGIC_WORD       = 32'h33574442;
  localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
  localparam int unsigned QDEPTH           = 2;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_HDR_TRUNC  = 4'd1,
    ST_HDR_BAD    = 4'd2,
    ST_TOTAL_BAD  = 4'd3,
    ST_FRAME_BAD  = 4'd4,
    ST_OP_BAD     = 4'd5,
    ST_BOUNDS     = 4'd6,
    ST_REC_CRC    = 4'd7,
    ST_SEQ_GAP    = 4'd8,
    ST_TORN       = 4'd9,
    ST_CLEAN      = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RECORD = 2'd1,
    PH_HALTED = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] record_sequence;
    logic        is_delete;
    logic [20:0] key_length;
    logic [24:0] value_length;
    logic        applied;
    logic [63:0] last_applied;
    logic        file_done;
  } out_item_t;

  // Classified event handed from the front to the back.
  typedef enum logic [1:0] {
    EV_PLAIN  = 2'd0,  // status final, no sequence work
    EV_HEADER = 2'd1,  // header valid: load expected sequence
    EV_RECORD = 2'd2   // record passed frame, op, bounds and CRC checks
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic        emit;
    logic [3:0]  status;
    logic [63:0] seq;
    logic        is_delete;
    logic [20:0] key_length;
    logic [24:0] value_length;
    logic        done;
  } event_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction
endpackage

// ===== hw/rtl/wfv_front.sv =====
`timescale 1ns / 1ps
module wfv_front import wfv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     ev_valid,
  input  logic     ev_ready,
  output event_t   ev_data,
  output logic     hdr_phase
);
  phase_t      phase_r, phase_nxt;
  logic [24:0] idx_r, idx_nxt;
  logic [31:0] fcrc_r, fcrc_nxt, hcrc_r, hcrc_nxt, rcrc_r, rcrc_nxt;
  logic [63:0] w0_r, w0_nxt, first_r, first_nxt;
  logic [31:0] hdr_crc_r, hdr_crc_nxt;
  logic [31:0] total_r, total_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [31:0] kl_r, kl_nxt, vl_r, vl_nxt, fh_r, fh_nxt, rc_r, rc_nxt;
  logic        acc;
  logic [7:0]  b;
  logic        eof;
  event_t      ev;
  logic        ev_fire;
  logic [33:0] len_sum;
  logic [31:0] rc_full;

  assign in_ready  = ev_ready;
  assign acc       = in_valid && in_ready;
  assign b         = in_data.data_byte;
  assign eof       = in_data.end_of_file;
  assign hdr_phase = (phase_r == PH_HEADER);
  assign rc_full   = {rc_r[23:0], b};
  assign len_sum   = 34'(REC_MIN) + {2'd0, kl_r} + {2'd0, vl_r};

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    fcrc_nxt    = fcrc_r;
    hcrc_nxt    = hcrc_r;
    rcrc_nxt    = rcrc_r;
    w0_nxt      = w0_r;
    first_nxt   = first_r;
    hdr_crc_nxt = hdr_crc_r;
    total_nxt   = total_r;
    seq_nxt     = seq_r;
    op_nxt      = op_r;
    kl_nxt      = kl_r;
    vl_nxt      = vl_r;
    fh_nxt      = fh_r;
    rc_nxt      = rc_r;
    ev          = '0;
    ev.kind     = EV_PLAIN;
    ev_fire     = 1'b0;
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (idx_r < 25'd28) fcrc_nxt = crc_byte(fcrc_r, b);
          if (idx_r < 25'd8) w0_nxt[8*idx_r[2:0] +: 8] = b;
          else if (idx_r >= 25'd20 && idx_r < 25'd28)
            first_nxt = {b, first_r[63:8]};
          else if (idx_r >= 25'd28) hdr_crc_nxt = {b, hdr_crc_r[31:8]};
          idx_nxt = idx_r + 25'd1;
          if (idx_r == 25'(HDR_BYTES - 1)) begin
            ev_fire = 1'b1;
            if (w0_r[31:0] != MAGIC_WORD || w0_r[47:32] != 16'd3 ||
                w0_r[63:48] != 16'(HDR_BYTES) ||
                {b, hdr_crc_r[31:8]} != ~fcrc_r) begin
              ev.emit = 1'b1; ev.status = ST_HDR_BAD; ev.done = 1'b1;
              phase_nxt = PH_HALTED;
            end else begin
              ev.kind = EV_HEADER;
              ev.seq  = first_r;
              ev.emit = eof; ev.status = ST_CLEAN; ev.done = eof;
              phase_nxt = eof ? PH_HALTED : PH_RECORD;
              idx_nxt = '0; hcrc_nxt = '1; rcrc_nxt = '1;
              total_nxt = '0; seq_nxt = '0; op_nxt = '0;
              kl_nxt = '0; vl_nxt = '0; fh_nxt = '0; rc_nxt = '0;
            end
          end else if (eof) begin
            ev_fire = 1'b1;
            ev.emit = 1'b1; ev.status = ST_HDR_TRUNC; ev.done = 1'b1;
            phase_nxt = PH_HALTED;
          end
        end
        PH_RECORD: begin
          if (idx_r < 25'd4 || ({7'd0, idx_r} + 32'd4) < total_r)
            rcrc_nxt = crc_byte(rcrc_r, b);
          if (idx_r >= 25'd4 && idx_r <= 25'd20) hcrc_nxt = crc_byte(hcrc_r, b);
          if (idx_r < 25'd4)       total_nxt = {total_r[23:0], b};
          else if (idx_r < 25'd12) seq_nxt   = {seq_r[55:0], b};
          else if (idx_r < 25'd13) op_nxt    = b;
          else if (idx_r < 25'd17) kl_nxt    = {kl_r[23:0], b};
          else if (idx_r < 25'd21) vl_nxt    = {vl_r[23:0], b};
          else if (idx_r < 25'd25) fh_nxt    = {fh_r[23:0], b};
          else                     rc_nxt    = rc_full;
          idx_nxt = idx_r + 25'd1;
          if (idx_r == 25'd3 && ({total_r[23:0], b} < 32'(REC_MIN) ||
              {total_r[23:0], b} > 32'(MAX_RECORD_BYTES))) begin
            ev_fire = 1'b1;
            ev.emit = 1'b1; ev.status = ST_TOTAL_BAD; ev.done = 1'b1;
            phase_nxt = PH_HALTED;
          end else if (idx_r >= 25'd4 && {7'd0, idx_r} + 32'd1 == total_r) begin
            ev_fire = 1'b1;
            ev.emit = 1'b1;
            ev.seq = seq_r;
            ev.is_delete = (op_r == 8'd2);
            ev.key_length = kl_r[20:0];
            ev.value_length = vl_r[24:0];
            if (fh_r != ~hcrc_r || kl_r == 32'd0 || kl_r > 32'(MAX_KEY_BYTES) ||
                vl_r > 32'(MAX_RECORD_BYTES))
              ev.status = ST_FRAME_BAD;
            else if (op_r != 8'd1 && op_r != 8'd2) ev.status = ST_OP_BAD;
            else if (len_sum != {2'd0, total_r}) ev.status = ST_BOUNDS;
            else if (rc_full != ~rcrc_r) ev.status = ST_REC_CRC;
            else begin
              ev.status = ST_OK;
              ev.kind = EV_RECORD;
            end
            // the back decides done for gaps; here it covers final errors
            ev.done = eof || (ev.status != ST_OK);
            phase_nxt = (eof || ev.status != ST_OK) ? PH_HALTED : PH_RECORD;
            idx_nxt = '0; hcrc_nxt = '1; rcrc_nxt = '1;
            total_nxt = '0; seq_nxt = '0; op_nxt = '0;
            kl_nxt = '0; vl_nxt = '0; fh_nxt = '0; rc_nxt = '0;
          end else if (eof) begin
            ev_fire = 1'b1;
            ev.emit = 1'b1; ev.status = ST_TORN; ev.done = 1'b1;
            phase_nxt = PH_HALTED;
          end
        end
        default: ;
      endcase
    end
  end

  // A sequence gap halts the stream too; the front sets ev.done
  // only for final statuses, so gap halting is enforced by the back.
  assign ev_valid = ev_fire;
  assign ev_data  = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      fcrc_r  <= '1;
      hcrc_r  <= '1;
      rcrc_r  <= '1;
      w0_r    <= '0;
      first_r <= '0;
      hdr_crc_r <= '0;
      total_r <= '0;
      seq_r   <= '0;
      op_r    <= '0;
      kl_r    <= '0;
      vl_r    <= '0;
      fh_r    <= '0;
      rc_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      fcrc_r  <= fcrc_nxt;
      hcrc_r  <= hcrc_nxt;
      rcrc_r  <= rcrc_nxt;
      w0_r    <= w0_nxt;
      first_r <= first_nxt;
      hdr_crc_r <= hdr_crc_nxt;
      total_r <= total_nxt;
      seq_r   <= seq_nxt;
      op_r    <= op_nxt;
      kl_r    <= kl_nxt;
      vl_r    <= vl_nxt;
      fh_r    <= fh_nxt;
      rc_r    <= rc_nxt;
    end
  end
endmodule

// ===== hw/rtl/wfv_queue.sv =====
`timescale 1ns / 1ps
module wfv_queue import wfv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  event_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output event_t rd_data
);
  localparam int unsigned AW = $clog2(QDEPTH);
  event_t         mem_r [QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ===== hw/rtl/wfv_back.sv =====
`timescale 1ns / 1ps
module wfv_back import wfv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ev_valid,
  output logic      ev_ready,
  input  event_t    ev_data,
  input  logic      cfg_valid,
  input  logic [63:0] cfg_data,
  input  logic      hdr_phase,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic [63:0] start_r, last_r, exp_r;
  logic [63:0] start_nxt, last_nxt, exp_nxt, exp_hdr;
  logic        halt_r, halt_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        take;

  assign ev_ready  = !ov_r || out_ready;
  assign take      = ev_valid && ev_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign exp_hdr   = (ev_data.seq > start_r + 64'd1) ? ev_data.seq : start_r + 64'd1;

  always_comb begin
    start_nxt = start_r;
    last_nxt  = last_r;
    exp_nxt   = exp_r;
    halt_nxt  = halt_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    if (cfg_valid) begin
      start_nxt = cfg_data;
      if (hdr_phase) last_nxt = cfg_data;
    end
    if (take && !halt_r) begin
      od_nxt.status          = ev_data.status;
      od_nxt.record_sequence = ev_data.seq;
      od_nxt.is_delete       = ev_data.is_delete;
      od_nxt.key_length      = ev_data.key_length;
      od_nxt.value_length    = ev_data.value_length;
      od_nxt.applied         = 1'b0;
      od_nxt.file_done       = ev_data.done;
      unique case (ev_data.kind)
        EV_HEADER: begin
          exp_nxt = exp_hdr;
          od_nxt.record_sequence = '0;
        end
        EV_RECORD: begin
          if (ev_data.seq > last_r) begin
            if (ev_data.seq != exp_r) begin
              od_nxt.status    = ST_SEQ_GAP;
              od_nxt.file_done = 1'b1;
            end else begin
              od_nxt.applied = 1'b1;
              last_nxt = ev_data.seq;
              exp_nxt  = exp_r + 64'd1;
            end
          end
        end
        default: ;
      endcase
      od_nxt.last_applied = od_nxt.applied ? ev_data.seq : last_r;
      if (ev_data.emit) begin
        ov_nxt = 1'b1;
        if (od_nxt.file_done) halt_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    if (!rst_n) begin
      start_r <= '0; last_r <= '0; exp_r <= '0; halt_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      start_r <= start_nxt; last_r <= last_nxt; exp_r <= exp_nxt;
      halt_r <= halt_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

// ===== hw/rtl/wal_frame_validator.sv =====
`timescale 1ns / 1ps
// channel | dir | signals                      | payload
// in      | in  | in_valid / in_ready          | in_item_t (data_byte, end_of_file)
// out     | out | out_valid / out_ready        | out_item_t
// cfg     | in  | cfg_valid / cfg_ready        | start_sequence, 64 bits
// One byte per cycle while the event queue has room; a result for its last byte
// passes front classify, queue and back sequence check into the output register.
// rst_n is synchronous, active low; no clearing pass.
// The two-entry event queue lets the front run while the output stalls.
// After a sequence gap the back drops any later events until reset.
module wal_frame_validator import wfv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  logic   fe_valid, fe_ready, q_valid, q_ready, hdr_phase;
  event_t fe_data, q_data;

  assign cfg_ready = 1'b1;

  wfv_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .ev_valid(fe_valid), .ev_ready(fe_ready), .ev_data(fe_data), .hdr_phase
  );
  wfv_queue u_queue (
    .clk, .rst_n, .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );
  wfv_back u_back (
    .clk, .rst_n, .ev_valid(q_valid), .ev_ready(q_ready), .ev_data(q_data),
    .cfg_valid, .cfg_data, .hdr_phase, .out_valid, .out_ready, .out_data
  );
endmodule

// ===== hw/rtl/wfv_checker.sv =====
`timescale 1ns / 1ps
module wfv_checker import wfv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.file_done)
    else $error("error status without file_done");
  a_applied_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.applied |->
      out_data.status == ST_OK && out_data.last_applied == out_data.record_sequence)
    else $error("applied inconsistent");
  a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.file_done |=> !out_valid)
    else $error("beat after file end");
endmodule

bind wal_frame_validator wfv_checker u_checker (.*);
